FILE: hdl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEFAULT = 80;
   localparam int ROWS_DEFAULT    = 25;

   // field widths
   localparam int OPCODE_W = 2;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 11;
   localparam int POS_W    = 11;
   localparam int CELL_W   = 16;
   localparam int COLOR_W  = 4;

   // stream packing
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_FG_COLOR = 1'b0;
   localparam logic REG_BG_COLOR = 1'b1;
   localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
   localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

   // character codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE   = 8'h0A;
   localparam logic [CHAR_W-1:0] BACKSPACE_CODE = 8'h08;
   localparam logic [CHAR_W-1:0] SPACE_CODE     = 8'h20;
   localparam logic [CHAR_W-1:0] NULL_CODE      = 8'h00;

   // cell contents after reset
   localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUT_CHAR  = 2'd0,
      OP_BACKSPACE = 2'd1,
      OP_CLEAR     = 2'd2,
      OP_READ_CELL = 2'd3
   } opcode_type;

   typedef struct packed {
      logic [COLOR_W-1:0] bg_color;
      logic [COLOR_W-1:0] fg_color;
   } cfg_type;

endpackage

FILE: hdl/tcw_csr.sv
`timescale 1ns / 1ps

module tcw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output tcw_pkg::cfg_type                    cfg
);

   logic                           write_en;
   logic                           reg_sel;
   logic [tcw_pkg::COLOR_W-1:0]    fg_ff, fg_in;
   logic [tcw_pkg::COLOR_W-1:0]    bg_ff, bg_in;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = csr_paddr[2];

   // register write decode
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (write_en) begin
         if (reg_sel == tcw_pkg::REG_FG_COLOR) begin
            fg_in = csr_pwdata[tcw_pkg::COLOR_W-1:0];
         end else begin
            bg_in = csr_pwdata[tcw_pkg::COLOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tcw_pkg::RESET_FG;
         bg_ff <= tcw_pkg::RESET_BG;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // read back
   always_comb begin
      if (reg_sel == tcw_pkg::REG_FG_COLOR) begin
         csr_prdata = tcw_pkg::CSR_DATA_W'(fg_ff);
      end else begin
         csr_prdata = tcw_pkg::CSR_DATA_W'(bg_ff);
      end
   end

   assign cfg.fg_color = fg_ff;
   assign cfg.bg_color = bg_ff;

endmodule

FILE: hdl/tcw_engine.sv
`timescale 1ns / 1ps

module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcw_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [tcw_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [tcw_pkg::CHAR_W-1:0]        req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]       req_cell_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tcw_pkg::CHAR_W-1:0]        rsp_serial_byte,
   output logic                              rsp_serial_valid,
   output logic [tcw_pkg::POS_W-1:0]         rsp_cursor_pos,
   output logic [tcw_pkg::CELL_W-1:0]        rsp_cell_data,
   output logic                              rsp_last
);

   localparam int CELLS  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CMP_W  = ADDR_W + tcw_pkg::INDEX_W;

   localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_ROW = ADDR_W'(CELLS - COLUMNS);
   localparam logic [ADDR_W:0]   CELLS_X    = (ADDR_W + 1)'(CELLS);
   localparam logic [ADDR_W:0]   COLUMNS_X  = (ADDR_W + 1)'(COLUMNS);
   localparam logic [COL_W:0]    COL_LIMIT  = (COL_W + 1)'(COLUMNS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_FILL,
      ST_RESP
   } state_type;

   // screen store
   logic [tcw_pkg::CELL_W-1:0]  screen_mem [CELLS];
   logic [tcw_pkg::CELL_W-1:0]  rdata_ff;
   logic                        wr_en;
   logic [ADDR_W-1:0]           waddr;
   logic [tcw_pkg::CELL_W-1:0]  wdata;
   logic [ADDR_W-1:0]           raddr;

   // control state
   state_type                   state_ff, state_in;
   logic [ADDR_W-1:0]           lin_ff, lin_in;
   logic [COL_W-1:0]            col_ff, col_in;
   logic [ADDR_W-1:0]           sweep_ff, sweep_in;
   logic                        pend_ff, pend_in;

   // result payload
   logic [tcw_pkg::CHAR_W-1:0]  byte_ff, byte_in;
   logic                        sv_ff, sv_in;
   logic [tcw_pkg::CELL_W-1:0]  cell_ff, cell_in;
   logic                        last_ff, last_in;

   logic                        accept;
   logic [tcw_pkg::CELL_W-1:0]  blank;
   logic [tcw_pkg::CELL_W-1:0]  written;
   logic [ADDR_W:0]             lin_p1;
   logic [ADDR_W:0]             lin_nl;
   logic [COL_W:0]              col_p1;
   logic                        in_range;
   tcw_pkg::opcode_type         opcode;

   assign opcode    = tcw_pkg::opcode_type'(req_opcode);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign blank     = {cfg.bg_color, cfg.fg_color, tcw_pkg::SPACE_CODE};
   assign written   = {cfg.bg_color, cfg.fg_color, req_char_code};

   // shared cursor arithmetic
   assign lin_p1   = {1'b0, lin_ff} + (ADDR_W + 1)'(1);
   assign lin_nl   = {1'b0, lin_ff} - (ADDR_W + 1)'(col_ff) + COLUMNS_X;
   assign col_p1   = {1'b0, col_ff} + (COL_W + 1)'(1);
   assign in_range = CMP_W'(req_cell_index) < CMP_W'(CELLS);

   // sequencer
   always_comb begin
      state_in = state_ff;
      lin_in   = lin_ff;
      col_in   = col_ff;
      sweep_in = sweep_ff;
      pend_in  = pend_ff;
      byte_in  = byte_ff;
      sv_in    = sv_ff;
      cell_in  = cell_ff;
      last_in  = last_ff;
      wr_en    = 1'b0;
      waddr    = lin_ff;
      wdata    = blank;
      raddr    = ADDR_W'(req_cell_index);

      case (state_ff)
         // clearing pass after reset
         ST_INIT: begin
            wr_en = 1'b1;
            waddr = sweep_ff;
            wdata = tcw_pkg::RESET_CELL;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               byte_in  = tcw_pkg::NULL_CODE;
               sv_in    = 1'b0;
               cell_in  = '0;
               last_in  = 1'b1;
               state_in = ST_RESP;
               case (opcode)
                  tcw_pkg::OP_PUT_CHAR: begin
                     byte_in = req_char_code;
                     sv_in   = 1'b1;
                     if (req_char_code == tcw_pkg::NEWLINE_CODE) begin
                        col_in = '0;
                        if (lin_nl >= CELLS_X) begin
                           lin_in   = BOTTOM_ROW;
                           sweep_in = '0;
                           pend_in  = 1'b0;
                           state_in = ST_SCROLL;
                        end else begin
                           lin_in = lin_nl[ADDR_W-1:0];
                        end
                     end else begin
                        wr_en = 1'b1;
                        waddr = lin_ff;
                        wdata = written;
                        if (col_p1 == COL_LIMIT) begin
                           col_in = '0;
                           if (lin_p1 == CELLS_X) begin
                              lin_in   = BOTTOM_ROW;
                              sweep_in = '0;
                              pend_in  = 1'b0;
                              state_in = ST_SCROLL;
                           end else begin
                              lin_in = lin_p1[ADDR_W-1:0];
                           end
                        end else begin
                           col_in = col_p1[COL_W-1:0];
                           lin_in = lin_p1[ADDR_W-1:0];
                        end
                     end
                  end
                  tcw_pkg::OP_BACKSPACE: begin
                     if (col_ff != '0) begin
                        col_in  = col_ff - COL_W'(1);
                        lin_in  = lin_ff - ADDR_W'(1);
                        wr_en   = 1'b1;
                        waddr   = lin_ff - ADDR_W'(1);
                        wdata   = blank;
                        byte_in = tcw_pkg::BACKSPACE_CODE;
                        sv_in   = 1'b1;
                        last_in = 1'b0;
                     end
                  end
                  tcw_pkg::OP_CLEAR: begin
                     lin_in   = '0;
                     col_in   = '0;
                     sweep_in = '0;
                     state_in = ST_FILL;
                  end
                  tcw_pkg::OP_READ_CELL: begin
                     if (in_range) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         // registered read data is ready
         ST_READ: begin
            cell_in  = rdata_ff;
            state_in = ST_RESP;
         end

         // move each cell up one row, reading each cell ahead of its write
         ST_SCROLL: begin
            raddr = ADDR_W'({1'b0, sweep_ff} + COLUMNS_X);
            if (pend_ff) begin
               wr_en = 1'b1;
               waddr = sweep_ff - ADDR_W'(1);
               wdata = rdata_ff;
            end
            if (sweep_ff == BOTTOM_ROW) begin
               pend_in  = 1'b0;
               state_in = ST_FILL;
            end else begin
               pend_in  = 1'b1;
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         // blank from the sweep position to the end of the store
         ST_FILL: begin
            wr_en = 1'b1;
            waddr = sweep_ff;
            wdata = blank;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_RESP;
            end else begin
               sweep_in = sweep_ff + ADDR_W'(1);
            end
         end

         // hold the result until taken; a backspace away from column zero walks its three bytes
         ST_RESP: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  last_in = (byte_ff == tcw_pkg::SPACE_CODE);
                  byte_in = (byte_ff == tcw_pkg::SPACE_CODE) ? tcw_pkg::BACKSPACE_CODE
                                                             : tcw_pkg::SPACE_CODE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         lin_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         lin_ff   <= lin_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
      end
      byte_ff <= byte_in;
      sv_ff   <= sv_in;
      cell_ff <= cell_in;
      last_ff <= last_in;
   end

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         screen_mem[waddr] <= wdata;
      end
      rdata_ff <= screen_mem[raddr];
   end

   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_serial_byte  = byte_ff;
   assign rsp_serial_valid = sv_ff;
   assign rsp_cursor_pos   = tcw_pkg::POS_W'(lin_ff);
   assign rsp_cell_data    = cell_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: hdl/text_console_writer.sv
`timescale 1ns / 1ps

// channel    direction  handshake          payload
// req_       in         tvalid / tready    tuser opcode, tdata char code and cell index
// rsp_       out        tvalid / tready    tuser serial valid, tdata byte, cursor, cell; tlast
// csr_       in         apb, pready high   fg_color at 0x0, bg_color at 0x4
//
// a scroll and a clear sweep one cell a cycle through the shared sweep counter and store port.
// after reset a clearing pass fills the store; register writes are taken meanwhile,
// req_tready stays low. req_tready is low from acceptance until the final result
// transaction; a stalled rsp_ holds the engine.

module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
   parameter int ROWS    = tcw_pkg::ROWS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcw_pkg::REQ_DATA_W-1:0]      req_tdata,   // char_code, cell_index, pad
   input  logic [tcw_pkg::OPCODE_W-1:0]        req_tuser,   // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // serial_byte, cursor_pos,
                                                            // cell_data, pad
   output logic                                rsp_tuser,   // serial_valid
   output logic                                rsp_tlast,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [tcw_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int RSP_USED = tcw_pkg::CHAR_W + tcw_pkg::POS_W + tcw_pkg::CELL_W;

   tcw_pkg::cfg_type                cfg;
   logic [tcw_pkg::CHAR_W-1:0]      serial_byte;
   logic [tcw_pkg::POS_W-1:0]       cursor_pos;
   logic [tcw_pkg::CELL_W-1:0]      cell_data;

   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_tvalid),
      .req_ready        (req_tready),
      .req_opcode       (req_tuser),
      .req_char_code    (req_tdata[7:0]),
      .req_cell_index   (req_tdata[18:8]),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .rsp_serial_byte  (serial_byte),
      .rsp_serial_valid (rsp_tuser),
      .rsp_cursor_pos   (cursor_pos),
      .rsp_cell_data    (cell_data),
      .rsp_last         (rsp_tlast)
   );

   // result packing, lowest field first
   assign rsp_tdata = {{(tcw_pkg::RSP_DATA_W - RSP_USED){1'b0}},
                       cell_data, cursor_pos, serial_byte};

endmodule

FILE: sim/tb_text_console_writer.sv
`timescale 1ns / 1ps

module tb_text_console_writer;

   localparam int COLS        = tcw_pkg::COLUMNS_DEFAULT;
   localparam int LINES       = tcw_pkg::ROWS_DEFAULT;
   localparam int CELLS       = COLS * LINES;
   localparam int CYCLE_LIMIT = 2_000_000;
   localparam int PHASES      = 4;

   localparam logic [tcw_pkg::CSR_ADDR_W-1:0] FG_ADDR = {tcw_pkg::REG_FG_COLOR, 2'b00};
   localparam logic [tcw_pkg::CSR_ADDR_W-1:0] BG_ADDR = {tcw_pkg::REG_BG_COLOR, 2'b00};

   // one result transaction of the console
   typedef struct packed {
      logic [tcw_pkg::CHAR_W-1:0] serial_byte;
      logic                       serial_valid;
      logic [tcw_pkg::POS_W-1:0]  cursor_pos;
      logic [tcw_pkg::CELL_W-1:0] cell_data;
      logic                       last;
   } console_result_type;

   // one row of the directed stimulus, with a typed answer where it is obvious
   typedef struct packed {
      tcw_pkg::opcode_type         op;
      logic [tcw_pkg::CHAR_W-1:0]  char_code;
      logic [tcw_pkg::INDEX_W-1:0] cell_index;
      logic                        typed;
      logic [tcw_pkg::CHAR_W-1:0]  exp_byte;
      logic                        exp_valid;
      logic [tcw_pkg::POS_W-1:0]   exp_pos;
      logic [tcw_pkg::CELL_W-1:0]  exp_cell;
   } directed_row_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [tcw_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [tcw_pkg::OPCODE_W-1:0]   req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [tcw_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           rsp_tlast;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [tcw_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [tcw_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // console shadow state
   logic [tcw_pkg::CELL_W-1:0]  screen_shadow [CELLS];
   int                          shadow_row;
   int                          shadow_col;
   logic [tcw_pkg::COLOR_W-1:0] shadow_fg;
   logic [tcw_pkg::COLOR_W-1:0] shadow_bg;

   console_result_type pending_results [$];
   directed_row_type   directed_rows [$];

   int error_count   = 0;
   int items_sent    = 0;
   int results_seen  = 0;
   int scroll_count  = 0;
   int color_changes = 0;
   int cycle_count   = 0;
   int burst_left    = 0;
   int ready_run     = 0;
   int ready_mode    = 0;

   text_console_writer #(
      .COLUMNS(COLS),
      .ROWS(LINES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),     // char_code, cell_index, pad
      .req_tuser(req_tuser),     // opcode
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),     // serial_byte, cursor_pos, cell_data, pad
      .rsp_tuser(rsp_tuser),     // serial_valid
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // queue one expected transaction with the current shadow cursor
   function automatic void push_result(logic [tcw_pkg::CHAR_W-1:0] sbyte, logic svalid,
                                       logic [tcw_pkg::CELL_W-1:0] cell_word,
                                       logic is_last);
      console_result_type r;
      r.serial_byte  = sbyte;
      r.serial_valid = svalid;
      r.cursor_pos   = tcw_pkg::POS_W'(shadow_row * COLS + shadow_col);
      r.cell_data    = cell_word;
      r.last         = is_last;
      pending_results.push_back(r);
   endfunction

   // apply one accepted request to the shadow console
   function automatic void console_predict(tcw_pkg::opcode_type op,
                                           logic [tcw_pkg::CHAR_W-1:0] ch,
                                           logic [tcw_pkg::INDEX_W-1:0] idx);
      logic [tcw_pkg::CELL_W-1:0] blank;
      logic [tcw_pkg::CELL_W-1:0] cell_word;
      int i;
      blank = {shadow_bg, shadow_fg, tcw_pkg::SPACE_CODE};
      case (op)
         tcw_pkg::OP_PUT_CHAR: begin
            if (ch == tcw_pkg::NEWLINE_CODE) begin
               shadow_col = 0;
               shadow_row++;
            end else begin
               screen_shadow[shadow_row * COLS + shadow_col] = {shadow_bg, shadow_fg, ch};
               shadow_col++;
               if (shadow_col >= COLS) begin
                  shadow_col = 0;
                  shadow_row++;
               end
            end
            // leaving the bottom row moves every line up
            if (shadow_row >= LINES) begin
               for (i = 0; i < CELLS - COLS; i++) screen_shadow[i] = screen_shadow[i + COLS];
               for (i = CELLS - COLS; i < CELLS; i++) screen_shadow[i] = blank;
               shadow_row = LINES - 1;
               scroll_count++;
            end
            push_result(ch, 1'b1, '0, 1'b1);
         end
         tcw_pkg::OP_BACKSPACE: begin
            if (shadow_col == 0) begin
               push_result(tcw_pkg::NULL_CODE, 1'b0, '0, 1'b1);
            end else begin
               shadow_col--;
               screen_shadow[shadow_row * COLS + shadow_col] = blank;
               push_result(tcw_pkg::BACKSPACE_CODE, 1'b1, '0, 1'b0);
               push_result(tcw_pkg::SPACE_CODE, 1'b1, '0, 1'b0);
               push_result(tcw_pkg::BACKSPACE_CODE, 1'b1, '0, 1'b1);
            end
         end
         tcw_pkg::OP_CLEAR: begin
            for (i = 0; i < CELLS; i++) screen_shadow[i] = blank;
            shadow_row = 0;
            shadow_col = 0;
            push_result(tcw_pkg::NULL_CODE, 1'b0, '0, 1'b1);
         end
         default: begin
            cell_word = (idx < CELLS) ? screen_shadow[idx] : '0;
            push_result(tcw_pkg::NULL_CODE, 1'b0, cell_word, 1'b1);
         end
      endcase
   endfunction

   // drive one request and wait until it is accepted
   task automatic send_item(tcw_pkg::opcode_type op, logic [tcw_pkg::CHAR_W-1:0] ch,
                            logic [tcw_pkg::INDEX_W-1:0] idx);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, idx, ch};
      do @(posedge clock); while (!req_tready);
      console_predict(op, ch, idx);
      items_sent++;
   endtask

   // sender runs in bursts with random gaps between them
   task automatic sender_gap();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // apb write, setup then access
   task automatic csr_write(logic [tcw_pkg::CSR_ADDR_W-1:0] addr,
                            logic [tcw_pkg::COLOR_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= tcw_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == FG_ADDR) shadow_fg = value;
      else shadow_bg = value;
      color_changes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // stop sending and let every expected transaction drain
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // random request, mostly text with newlines at the given rate
   task automatic random_item(int newline_pct);
      int pick;
      int sel;
      int back;
      int pos;
      logic [tcw_pkg::INDEX_W-1:0] idx;
      logic [tcw_pkg::CHAR_W-1:0] ch;
      pick = $urandom_range(0, 99);
      idx  = tcw_pkg::INDEX_W'($urandom_range(0, 2047));
      ch   = tcw_pkg::CHAR_W'($urandom_range(0, 255));
      if (pick < 2) begin
         send_item(tcw_pkg::OP_CLEAR, ch, idx);
      end else if (pick < 10) begin
         // reads land near the cursor, anywhere, or past the store
         sel = $urandom_range(0, 7);
         pos = shadow_row * COLS + shadow_col;
         back = $urandom_range(0, 3);
         if (sel == 0) idx = tcw_pkg::INDEX_W'($urandom_range(CELLS, 2047));
         else if (sel < 4) idx = tcw_pkg::INDEX_W'((pos >= back) ? pos - back : 0);
         else idx = tcw_pkg::INDEX_W'($urandom_range(0, CELLS - 1));
         send_item(tcw_pkg::OP_READ_CELL, ch, idx);
      end else if (pick < 18) begin
         send_item(tcw_pkg::OP_BACKSPACE, ch, idx);
      end else if (pick < 18 + newline_pct) begin
         send_item(tcw_pkg::OP_PUT_CHAR, tcw_pkg::NEWLINE_CODE, idx);
      end else begin
         send_item(tcw_pkg::OP_PUT_CHAR, ch, idx);
      end
   endtask

   function automatic void add_row(tcw_pkg::opcode_type op, logic [tcw_pkg::CHAR_W-1:0] ch,
                                   logic [tcw_pkg::INDEX_W-1:0] idx, logic typed,
                                   logic [tcw_pkg::CHAR_W-1:0] sbyte, logic svalid,
                                   logic [tcw_pkg::POS_W-1:0] pos,
                                   logic [tcw_pkg::CELL_W-1:0] cell_word);
      directed_row_type row;
      row = '{op, ch, idx, typed, sbyte, svalid, pos, cell_word};
      directed_rows.push_back(row);
   endfunction

   // receiver stalls on its own pattern of runs
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_run  = $urandom_range(4, 40);
         ready_mode = $urandom_range(0, 2);
      end
      ready_run--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 2) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      console_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction, tdata %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[7:0] !== exp_r.serial_byte) begin
               $error("serial_byte expected %0d got %0d", exp_r.serial_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tuser !== exp_r.serial_valid) begin
               $error("serial_valid expected %0d got %0d", exp_r.serial_valid, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[18:8] !== exp_r.cursor_pos) begin
               $error("cursor_pos expected %0d got %0d", exp_r.cursor_pos, rsp_tdata[18:8]);
               error_count++;
            end
            if (rsp_tdata[34:19] !== exp_r.cell_data) begin
               $error("cell_data expected %h got %h", exp_r.cell_data, rsp_tdata[34:19]);
               error_count++;
            end
            if (rsp_tlast !== exp_r.last) begin
               $error("last expected %0d got %0d", exp_r.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int i;
      int p;
      int n;
      int phase_fg [PHASES];
      int phase_bg [PHASES];
      int phase_items [PHASES];
      int phase_newline [PHASES];
      directed_row_type row;
      console_result_type typed_r;

      for (i = 0; i < CELLS; i++) screen_shadow[i] = tcw_pkg::RESET_CELL;
      shadow_row = 0;
      shadow_col = 0;
      shadow_fg  = tcw_pkg::RESET_FG;
      shadow_bg  = tcw_pkg::RESET_BG;

      // phase settings: color extremes, a random pair, long lines in one phase
      phase_fg = '{0, 15, $urandom_range(1, 14), 0};
      phase_bg = '{0, 15, $urandom_range(1, 14), 15};
      phase_items = '{40, 80, 30, 30};
      phase_newline = '{30, 1, 35, 40};

      // directed rows: extremes, every opcode, column zero and out of range reads
      add_row(tcw_pkg::OP_READ_CELL, 8'hFF, 11'd0, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, tcw_pkg::RESET_CELL);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd1999, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, tcw_pkg::RESET_CELL);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd2000, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, 16'h0000);
      add_row(tcw_pkg::OP_READ_CELL, 8'hFF, 11'h7FF, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, 16'h0000);
      add_row(tcw_pkg::OP_BACKSPACE, 8'hFF, 11'h7FF, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, 16'h0000);
      add_row(tcw_pkg::OP_PUT_CHAR, 8'h00, 11'h7FF, 1'b1, 8'h00, 1'b1, 11'd1, 16'h0000);
      add_row(tcw_pkg::OP_PUT_CHAR, 8'hFF, 11'd0, 1'b1, 8'hFF, 1'b1, 11'd2, 16'h0000);
      add_row(tcw_pkg::OP_PUT_CHAR, 8'h41, 11'd5, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd0, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd3, 16'h0F00);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd1, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd3, 16'h0FFF);
      add_row(tcw_pkg::OP_BACKSPACE, 8'h00, 11'd0, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd2, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_PUT_CHAR, tcw_pkg::NEWLINE_CODE, 11'd0, 1'b1,
              tcw_pkg::NEWLINE_CODE, 1'b1, 11'd80, 16'h0000);
      add_row(tcw_pkg::OP_BACKSPACE, 8'h00, 11'd0, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd80, 16'h0000);
      add_row(tcw_pkg::OP_PUT_CHAR, 8'h55, 11'h2AA, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_PUT_CHAR, 8'hAA, 11'h555, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_PUT_CHAR, tcw_pkg::BACKSPACE_CODE, 11'd0, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd80, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd82, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_CLEAR, 8'hFF, 11'h7FF, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, 16'h0000);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd0, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, tcw_pkg::RESET_CELL);
      add_row(tcw_pkg::OP_READ_CELL, 8'h00, 11'd81, 1'b1,
              tcw_pkg::NULL_CODE, 1'b0, 11'd0, tcw_pkg::RESET_CELL);
      add_row(tcw_pkg::OP_PUT_CHAR, tcw_pkg::SPACE_CODE, 11'd0, 1'b0, '0, 1'b0, '0, '0);
      add_row(tcw_pkg::OP_BACKSPACE, 8'h00, 11'd0, 1'b0, '0, 1'b0, '0, '0);

      // reset, then wait out the clearing pass
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (!req_tready);

      // directed part at reset colors
      for (n = 0; n < directed_rows.size(); n++) begin
         row = directed_rows[n];
         send_item(row.op, row.char_code, row.cell_index);
         if (row.typed) begin
            typed_r = '{row.exp_byte, row.exp_valid, row.exp_pos, row.exp_cell, 1'b1};
            void'(pending_results.pop_back());
            pending_results.push_back(typed_r);
         end
         sender_gap();
      end

      // random phases, colors changed only while idle
      for (p = 0; p < PHASES; p++) begin
         drain_results();
         csr_write(FG_ADDR, tcw_pkg::COLOR_W'(phase_fg[p]));
         csr_write(BG_ADDR, tcw_pkg::COLOR_W'(phase_bg[p]));
         for (i = 0; i < phase_items[p]; i++) begin
            random_item(phase_newline[p]);
            sender_gap();
         end
      end

      drain_results();
      repeat (50) @(posedge clock);

      $display("run covered %0d requests, %0d result transactions, %0d scrolls",
               items_sent, results_seen, scroll_count);
      $display("color register writes: %0d, leftover expectations: %0d",
               color_changes, pending_results.size());
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
